// ===== design/qbe_pkg.sv =====
// Shared types and constants for the quadratic Bezier easing evaluator.
`default_nettype none
package qbe_pkg;
	// Per-stage control handed into every cell of a chain
	typedef struct packed {
		logic en;   // pipeline advance
		logic vld;  // transaction present at the cell input
	} qbe_stg_t;

	// ctrl_x below ONE >> QTR_SHIFT selects the numerator/denominator form
	localparam int QTR_SHIFT = 2;
endpackage
`default_nettype wire

// ===== design/qbe_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root (one root bit per cell).
`default_nettype none
module qbe_sqrt_cell #(
	parameter int RB = 17,  // root bits
	parameter int SW = 52   // sideband width
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire qbe_pkg::qbe_stg_t ctl,
	input  wire logic [2*RB-1:0]   rad,
	input  wire logic [RB+2:0]     rem,
	input  wire logic [RB-1:0]     root,
	input  wire logic [SW-1:0]     side,
	output logic                   vld_q,
	output logic [2*RB-1:0]        rad_q,
	output logic [RB+2:0]          rem_q,
	output logic [RB-1:0]          root_q,
	output logic [SW-1:0]          side_q
);
	localparam int RW = RB + 3;

	logic [RW-1:0] rem_sh;
	logic [RW-1:0] sub;
	logic          take;

	// Bring down two radicand bits and try the next root bit
	assign rem_sh = {rem[RW-3:0], rad[2*RB-1:2*RB-2]};
	assign sub    = {1'b0, root, 2'b01};
	assign take   = (rem_sh >= sub);

	// Hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.en) begin
			vld_q <= ctl.vld;
		end
	end

	// Advance the partial root and remainder
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			rad_q  <= {rad[2*RB-3:0], 2'b00};
			rem_q  <= take ? (rem_sh - sub) : rem_sh;
			root_q <= {root[RB-2:0], take};
			side_q <= side;
		end
	end
endmodule
`default_nettype wire

// ===== design/qbe_div_cell.sv =====
// One step cell of the pipelined restoring divider (one quotient bit per cell).
`default_nettype none
module qbe_div_cell #(
	parameter int NW = 33,  // dividend and quotient bits
	parameter int DW = 18,  // divisor bits
	parameter int SW = 35   // sideband width
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire qbe_pkg::qbe_stg_t ctl,
	input  wire logic [NW-1:0]     num,
	input  wire logic [DW-1:0]     den,
	input  wire logic [DW-1:0]     rem,
	input  wire logic [NW-1:0]     quo,
	input  wire logic [SW-1:0]     side,
	output logic                   vld_q,
	output logic [NW-1:0]          num_q,
	output logic [DW-1:0]          den_q,
	output logic [DW-1:0]          rem_q,
	output logic [NW-1:0]          quo_q,
	output logic [SW-1:0]          side_q
);
	logic [DW:0] rem_sh;
	logic [DW:0] diff;
	logic        take;

	// Shift in the next dividend bit and compare with the divisor
	assign rem_sh = {rem, num[NW-1]};
	assign take   = (rem_sh >= {1'b0, den});
	assign diff   = rem_sh - {1'b0, den};

	// Hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.en) begin
			vld_q <= ctl.vld;
		end
	end

	// Advance the partial quotient and remainder
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			num_q  <= {num[NW-2:0], 1'b0};
			den_q  <= den;
			rem_q  <= take ? diff[DW-1:0] : rem_sh[DW-1:0];
			quo_q  <= {quo[NW-2:0], take};
			side_q <= side;
		end
	end
endmodule
`default_nettype wire

// ===== design/quadratic_bezier_easing_eval_top.sv =====
// Top level of the quadratic Bezier easing evaluator: clamp, root and divider chains, polynomial.
//
// Evaluates f(position) on the quadratic Bezier through (0,0), (ctrl_x, ctrl_y) and (1,1), all
// unsigned fixed point with FRAC_BITS fraction bits. The block takes one transaction per cycle
// while the output is not stalled and passes each through, in order, 3 front stages,
// FRAC_BITS+1 square-root cells, 1 divider setup stage, 2*FRAC_BITS+1 divider cells and 3
// polynomial stages; the long division, one quotient bit per cell, is the longest chain. A stall
// on the output holds the whole pipeline; in_ready is low only while a finished result waits.
`default_nettype none
module quadratic_bezier_easing_eval_top #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [FRAC_BITS:0]   ctrl_x,
	input  wire logic [FRAC_BITS:0]   ctrl_y,
	input  wire logic [FRAC_BITS:0]   position,
	input  wire logic                 linear,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [FRAC_BITS:0]        curve_value
);
	localparam int F   = FRAC_BITS;
	localparam int VW  = F + 1;          // value width
	localparam int RB  = F + 1;          // root bits
	localparam int W   = 2 * RB;         // radicand width
	localparam int NW  = 2 * F + 1;      // dividend width
	localparam int DW  = F + 2;          // divisor width
	localparam int SQW = 3 * VW + 1;     // sideband through the root chain
	localparam int DVW = 2 * VW + 1;     // sideband through the divider chain
	localparam logic [VW-1:0] ONE = VW'(1) << F;
	localparam logic [VW-1:0] QTR = ONE >> qbe_pkg::QTR_SHIFT;

	logic en;

	// Advance everything unless a finished result is waiting
	assign en       = out_ready | ~out_valid;
	assign in_ready = en;

	// Stage 1: clamp inputs
	logic          v_s1, l_s1;
	logic [VW-1:0] a_s1, b_s1, x_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= (ctrl_x > ONE) ? ONE : ctrl_x;
			b_s1 <= (ctrl_y > ONE) ? ONE : ctrl_y;
			x_s1 <= (position > ONE) ? ONE : position;
			l_s1 <= linear;
		end
	end

	// Stage 2: products a*a and a*x
	logic          v_s2, l_s2;
	logic [VW-1:0] a_s2, b_s2, x_s2;
	logic [2*VW-1:0] aa_s2, ax_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			aa_s2 <= a_s1 * a_s1;
			ax_s2 <= a_s1 * x_s1;
			a_s2  <= a_s1;
			b_s2  <= b_s1;
			x_s2  <= x_s1;
			l_s2  <= l_s1;
		end
	end

	// Stage 3: radicand a*a + x*ONE - 2*a*x, floored at zero
	logic [W:0]    pos_c, neg_c;
	logic          v_s3, l_s3;
	logic [VW-1:0] a_s3, b_s3, x_s3;
	logic [W-1:0]  disc_s3;

	assign pos_c = (W+1)'(aa_s2) + ((W+1)'(x_s2) << F);
	assign neg_c = (W+1)'(ax_s2) << 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			disc_s3 <= (pos_c >= neg_c) ? W'(pos_c - neg_c) : '0;
			a_s3    <= a_s2;
			b_s3    <= b_s2;
			x_s3    <= x_s2;
			l_s3    <= l_s2;
		end
	end

	// Square-root chain: one root bit per cell
	logic            sq_v    [0:RB];
	logic [W-1:0]    sq_rad  [0:RB];
	logic [RB+2:0]   sq_rem  [0:RB];
	logic [RB-1:0]   sq_root [0:RB];
	logic [SQW-1:0]  sq_side [0:RB];

	assign sq_v[0]    = v_s3;
	assign sq_rad[0]  = disc_s3;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_side[0] = {a_s3, b_s3, x_s3, l_s3};

	for (genvar k = 0; k < RB; k++) begin : g_sqrt
		qbe_pkg::qbe_stg_t ctl;
		assign ctl.en  = en;
		assign ctl.vld = sq_v[k];
		qbe_sqrt_cell #(.RB(RB), .SW(SQW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.rad    (sq_rad[k]),
			.rem    (sq_rem[k]),
			.root   (sq_root[k]),
			.side   (sq_side[k]),
			.vld_q  (sq_v[k+1]),
			.rad_q  (sq_rad[k+1]),
			.rem_q  (sq_rem[k+1]),
			.root_q (sq_root[k+1]),
			.side_q (sq_side[k+1])
		);
	end

	// Divider setup: pick the form by ctrl_x
	logic [VW-1:0] a_r, b_r, x_r, s_r;
	logic          l_r;
	logic          v_s4;
	logic [NW-1:0] num_s4;
	logic [DW-1:0] den_s4;
	logic [DVW-1:0] side_s4;

	assign {a_r, b_r, x_r, l_r} = sq_side[RB];
	assign s_r = sq_root[RB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_v[RB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (a_r < QTR) begin
				num_s4 <= (s_r >= a_r) ? (NW'(s_r - a_r) << F) : '0;
				den_s4 <= DW'(ONE) - (DW'(a_r) << 1);
			end else begin
				num_s4 <= NW'(x_r) << F;
				den_s4 <= DW'(a_r) + DW'(s_r);
			end
			side_s4 <= {b_r, x_r, l_r};
		end
	end

	// Divider chain: one quotient bit per cell
	logic            dv_v    [0:NW];
	logic [NW-1:0]   dv_num  [0:NW];
	logic [DW-1:0]   dv_den  [0:NW];
	logic [DW-1:0]   dv_rem  [0:NW];
	logic [NW-1:0]   dv_quo  [0:NW];
	logic [DVW-1:0]  dv_side [0:NW];

	assign dv_v[0]    = v_s4;
	assign dv_num[0]  = num_s4;
	assign dv_den[0]  = den_s4;
	assign dv_rem[0]  = '0;
	assign dv_quo[0]  = '0;
	assign dv_side[0] = side_s4;

	for (genvar k = 0; k < NW; k++) begin : g_div
		qbe_pkg::qbe_stg_t ctl;
		assign ctl.en  = en;
		assign ctl.vld = dv_v[k];
		qbe_div_cell #(.NW(NW), .DW(DW), .SW(DVW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.num    (dv_num[k]),
			.den    (dv_den[k]),
			.rem    (dv_rem[k]),
			.quo    (dv_quo[k]),
			.side   (dv_side[k]),
			.vld_q  (dv_v[k+1]),
			.num_q  (dv_num[k+1]),
			.den_q  (dv_den[k+1]),
			.rem_q  (dv_rem[k+1]),
			.quo_q  (dv_quo[k+1]),
			.side_q (dv_side[k+1])
		);
	end

	// Polynomial stage 1: clamp t, form 2(1-t)t
	logic [VW-1:0]   b_d, x_d, t_c;
	logic            l_d;
	logic [2*VW-1:0] omt_t;
	logic            v_s5, l_s5;
	logic [VW-1:0]   t_s5, b_s5, x_s5, p_s5;

	assign {b_d, x_d, l_d} = dv_side[NW];
	assign t_c   = (dv_quo[NW] > NW'(ONE)) ? ONE : dv_quo[NW][VW-1:0];
	assign omt_t = (ONE - t_c) * t_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= dv_v[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s5 <= omt_t[2*F-1:F-1];
			t_s5 <= t_c;
			b_s5 <= b_d;
			x_s5 <= x_d;
			l_s5 <= l_d;
		end
	end

	// Polynomial stage 2: q = p*b, r = t*t
	logic [2*VW-1:0] pb_c, tt_c;
	logic            v_s6, l_s6;
	logic [VW:0]     q_s6, r_s6;
	logic [VW-1:0]   x_s6;

	assign pb_c = p_s5 * b_s5;
	assign tt_c = t_s5 * t_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s6 <= pb_c[2*VW-1:F];
			r_s6 <= tt_c[2*VW-1:F];
			x_s6 <= x_s5;
			l_s6 <= l_s5;
		end
	end

	// Output stage: sum, saturate, or pass position for the straight line
	logic [VW+1:0] sum_c;

	assign sum_c = (VW+2)'(q_s6) + (VW+2)'(r_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (l_s6) begin
				curve_value <= x_s6;
			end else begin
				curve_value <= (sum_c > (VW+2)'(ONE)) ? ONE : sum_c[VW-1:0];
			end
		end
	end

	// Result never exceeds 1.0
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (curve_value <= ONE))
		else $error("curve_value above 1.0");

	// Divisor into the divider chain is never zero
	a_den_nz: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (den_s4 != '0))
		else $error("zero divisor entering divider");

	// Square root of a radicand bounded by ONE*ONE stays within 1.0
	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		sq_v[RB] |-> (sq_root[RB] <= ONE))
		else $error("square root above 1.0");

	// A stalled result holds its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(curve_value)))
		else $error("stalled result changed");
endmodule
`default_nettype wire

// ===== tb/sv/tb_quadratic_bezier_easing_eval_top.sv =====
// Self-checking testbench for the quadratic Bezier easing evaluator.
`timescale 1ns / 100ps
`default_nettype none

// Holds predicted curve values and checks results against them in order
class easing_scoreboard;
	logic [16:0] pending_values[$];
	int mismatches;
	int checked;

	// Integer square root, truncated
	static function logic [63:0] root_floor(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	static function logic [63:0] sat_unit(logic [63:0] v);
		return (v > 64'd65536) ? 64'd65536 : v;
	endfunction

	// Predict the eased value for one transaction
	static function logic [16:0] eased_value(logic [16:0] cx, logic [16:0] cy,
			logic [16:0] px, logic lin);
		logic [63:0] a, b, x, pos, neg, rad, s, t, num, p, q, r, res;
		a = sat_unit(cx);
		b = sat_unit(cy);
		x = sat_unit(px);
		if (lin) return x[16:0];
		pos = a * a + (x << 16);
		neg = 2 * a * x;
		rad = (pos >= neg) ? pos - neg : 0;
		s = root_floor(rad);
		if (a < (64'd65536 >> qbe_pkg::QTR_SHIFT)) begin
			num = (s >= a) ? s - a : 0;
			t = (num << 16) / (64'd65536 - 2 * a);
		end else begin
			t = (x << 16) / (a + s);
		end
		t = sat_unit(t);
		p = (2 * (64'd65536 - t) * t) >> 16;
		q = (p * b) >> 16;
		r = (t * t) >> 16;
		res = sat_unit(q + r);
		return res[16:0];
	endfunction

	function void note_input(logic [16:0] cx, logic [16:0] cy, logic [16:0] px, logic lin);
		pending_values.push_back(eased_value(cx, cy, px, lin));
	endfunction

	function void check_result(logic [16:0] got);
		logic [16:0] want;
		checked++;
		if (pending_values.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %0d", $time, got);
			mismatches++;
			return;
		end
		want = pending_values.pop_front();
		if (want !== got) begin
			$display("%0t: curve_value mismatch, expected %0d, actual %0d", $time, want, got);
			mismatches++;
		end
	endfunction
endclass

module tb_quadratic_bezier_easing_eval_top;
	localparam int LATENCY = 3 * 16 + 9;
	localparam longint CYCLE_LIMIT = 200000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [16:0] ctrl_x = 0;
	logic [16:0] ctrl_y = 0;
	logic [16:0] position = 0;
	logic linear = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [16:0] curve_value;

	easing_scoreboard sb = new();
	bit calm = 0;
	longint cycles = 0;
	int sent = 0;

	quadratic_bezier_easing_eval_top #(.FRAC_BITS(16)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.ctrl_x(ctrl_x), .ctrl_y(ctrl_y), .position(position), .linear(linear),
		.out_valid(out_valid), .out_ready(out_ready), .curve_value(curve_value)
	);

	always #5 clk = ~clk;

	// Abort on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("quadratic_bezier_easing_eval_top test failed");
			$finish;
		end
	end

	// Check each accepted result
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(curve_value);
	end

	// Drive the receiver stalls in bursts
	initial begin : sink
		int n;
		@(posedge arst_n);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 0;
				n = $urandom_range(1, 11);
				repeat (n) @(posedge clk);
			end
			out_ready <= 1;
			n = $urandom_range(1, 20);
			repeat (n) @(posedge clk);
		end
	end

	// Present one transaction and hold it until accepted
	task automatic send_item(logic [16:0] cx, logic [16:0] cy, logic [16:0] px, logic lin);
		int n;
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 0;
			n = $urandom_range(1, 11);
			repeat (n) @(posedge clk);
		end
		in_valid <= 1;
		ctrl_x <= cx;
		ctrl_y <= cy;
		position <= px;
		linear <= lin;
		do @(posedge clk); while (!in_ready);
		sb.note_input(cx, cy, px, lin);
		sent++;
	endtask

	function automatic logic [16:0] pick_field();
		case ($urandom_range(0, 9))
			0: return 17'd0;
			1: return 17'd65536;
			2: return 17'h1FFFF;
			3: return 17'($urandom_range(65537, 131071));
			4: return 17'($urandom_range(16000, 17000));
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	initial begin : stim
		logic [16:0] corners[5];
		int i;
		corners = '{17'd0, 17'd1, 17'd16384, 17'd65536, 17'h1FFFF};
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: corners, the a-near-quarter boundary, the linear path
		for (i = 0; i < 5; i++) send_item(corners[i], corners[4 - i], corners[(i + 2) % 5], 0);
		send_item(17'd16383, 17'd40000, 17'd30000, 0);
		send_item(17'd16384, 17'd40000, 17'd30000, 0);
		send_item(17'd32768, 17'd32768, 17'd32768, 0);
		send_item(17'd65536, 17'd0, 17'd1, 0);
		send_item(17'd0, 17'd65536, 17'd65535, 0);
		send_item(17'd100, 17'd200, 17'h1FFFF, 1);
		send_item(17'd100, 17'd200, 17'd12345, 1);
		send_item(17'd100, 17'd200, 17'd0, 1);
		// Hold off until the pipeline has drained
		in_valid <= 0;
		while (sb.pending_values.size() != 0) @(posedge clk);
		// Random traffic; the tail runs without idling
		for (i = 0; i < 1000; i++) begin
			if (i == 850) calm = 1;
			send_item(pick_field(), pick_field(), pick_field(), $urandom_range(0, 7) == 0);
		end
		in_valid <= 0;
		while (sb.pending_values.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		$display("Sent %0d transactions (directed corners, linear path, random with stalls);",
			sent);
		$display("checked %0d results with %0d mismatches.", sb.checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_values.size() == 0)
			$display("quadratic_bezier_easing_eval_top test passed");
		else
			$display("quadratic_bezier_easing_eval_top test failed");
		$finish;
	end
endmodule
`default_nettype wire
